// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== rtl/bhpq_pkg.sv =====
// types and codes of the binary heap priority queue
// no dependencies
package bhpq_pkg;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 9;
    localparam int FIELD_WIDTH  = 32;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_INSERTED = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_EXTRACT = 1'b1
    } req_t;
endpackage

// ===== rtl/bhpq_req_if.sv =====
// request channel interface
// depends on bhpq_pkg
interface bhpq_req_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [bhpq_pkg::FIELD_WIDTH-1:0] key;
    logic [bhpq_pkg::FIELD_WIDTH-1:0] payload;
    modport source (output valid, req_type, key, payload, input ready);
    modport sink (input valid, req_type, key, payload, output ready);
endinterface

// ===== rtl/bhpq_rsp_if.sv =====
// result channel interface
// depends on bhpq_pkg
interface bhpq_rsp_if;
    logic valid;
    logic ready;
    logic [bhpq_pkg::STATUS_WIDTH-1:0] status;
    logic [bhpq_pkg::FIELD_WIDTH-1:0] out_key;
    logic [bhpq_pkg::FIELD_WIDTH-1:0] out_payload;
    logic [bhpq_pkg::COUNT_WIDTH-1:0] count;
    modport source (output valid, status, out_key, out_payload, count, input ready);
    modport sink (input valid, status, out_key, out_payload, count, output ready);
endinterface

// ===== rtl/bhpq_ram.sv =====
// generic single port write, single port read ram with registered read
// no dependencies
module bhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// binary heap priority queue top level: sequencer plus entry store ram
// depends on bhpq_pkg, bhpq_req_if, bhpq_rsp_if, bhpq_ram, assert_macros.svh
//
//  channel | dir | payload
//  req     | in  | req_type, key, payload
//  rsp     | out | status, out_key, out_payload, count
//  cfg     | in  | order_mode via cfg_we / cfg_wdata
//
// full, empty and insert into an empty heap: result beat valid the cycle after acceptance
// insert: the entry is written at the end, then climbs by compare and swap with its parent
// extract: read the root, then the last entry, which becomes the new root and sinks:
// read left and right child, move the better child up; a last write when it settles
// reset is asynchronous active low, clears count and order; no clearing pass of the ram
// a finished result waits in the output register; the next request is taken
// the cycle after that result beat has gone
`include "assert_macros.svh"
module binary_heap_priority_queue #(
    parameter int DEPTH = 256,
    parameter int KEY_WIDTH = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic       cfg_wdata,
    bhpq_req_if.sink   req,
    bhpq_rsp_if.source rsp
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_INS_CMP, S_SWAP2, S_EXT_RD0, S_EXT_RDL, S_SK_RDL, S_SK_RDR, S_SK_FIN
    } state_t;

    state_t state_reg, state_next;
    logic order_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;       // current node
    logic [AW-1:0] oth_reg, oth_next;       // parent on the way up
    logic [EW-1:0] node_reg, node_next;     // entry being moved
    logic [EW-1:0] oth_ent_reg, oth_ent_next;
    logic [EW-1:0] lft_reg, lft_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [bhpq_pkg::STATUS_WIDTH-1:0] status_reg, status_next;
    logic [EW-1:0] res_reg, res_next;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;

    bhpq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    // strict worse: a belongs below b
    function automatic logic worse(input logic mx, input logic [EW-1:0] a,
                                   input logic [EW-1:0] b);
        logic [KEY_WIDTH-1:0] ka, kb;
        ka = a[EW-1 -: KEY_WIDTH];
        kb = b[EW-1 -: KEY_WIDTH];
        return mx ? (ka < kb) : (ka > kb);
    endfunction

    // child indexes of the current node, wide enough to compare with the count
    logic [IW-1:0] lchild, rchild, ch_lchild;
    logic use_r;
    logic [AW-1:0] ch_idx;
    logic [EW-1:0] ch_ent;
    logic [AW-1:0] ins_parent, up_parent;

    assign lchild = {1'b0, idx_reg, 1'b1};
    assign rchild = lchild + IW'(1);
    // right child only when it exists and the left one is strictly worse
    assign use_r = (rchild < IW'(count_reg)) && worse(order_reg, lft_reg, rd_data);
    assign ch_idx = use_r ? rchild[AW-1:0] : lchild[AW-1:0];
    assign ch_ent = use_r ? rd_data : lft_reg;
    assign ch_lchild = {1'b0, ch_idx, 1'b1};
    assign ins_parent = AW'((count_reg - CW'(1)) >> 1);
    assign up_parent = (oth_reg - AW'(1)) >> 1;

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.out_key = bhpq_pkg::FIELD_WIDTH'(res_reg[EW-1 -: KEY_WIDTH]);
    assign rsp.out_payload = bhpq_pkg::FIELD_WIDTH'(res_reg[PAYLOAD_WIDTH-1:0]);
    assign rsp.count = bhpq_pkg::COUNT_WIDTH'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        oth_next = oth_reg;
        node_next = node_reg;
        oth_ent_next = oth_ent_reg;
        lft_next = lft_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next = status_reg;
        res_next = res_reg;
        wr_en = 1'b0;
        wr_addr = idx_reg;
        wr_data = node_reg;
        rd_addr = '0;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    res_next = '0;
                    if (req.req_type == bhpq_pkg::REQ_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = bhpq_pkg::ST_FULL;
                            rsp_valid_next = 1'b1;
                        end
                        else
                        begin
                            // new entry goes to the end, then climbs
                            node_next = {req.key[KEY_WIDTH-1:0], req.payload[PAYLOAD_WIDTH-1:0]};
                            idx_next = count_reg[AW-1:0];
                            wr_en = 1'b1;
                            wr_addr = count_reg[AW-1:0];
                            wr_data = node_next;
                            count_next = count_reg + CW'(1);
                            status_next = bhpq_pkg::ST_INSERTED;
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                oth_next = ins_parent;
                                rd_addr = ins_parent;
                                state_next = S_INS_CMP;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = bhpq_pkg::ST_EMPTY;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        // read the root first
                        status_next = bhpq_pkg::ST_EXTRACTED;
                        count_next = count_reg - CW'(1);
                        rd_addr = '0;
                        state_next = S_EXT_RD0;
                    end
                end
            end
            S_INS_CMP:
            begin
                // parent entry on the read port
                if (worse(order_reg, rd_data, node_reg))
                begin
                    oth_ent_next = rd_data;
                    wr_en = 1'b1;
                    wr_addr = oth_reg;
                    wr_data = node_reg;
                    state_next = S_SWAP2;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SWAP2:
            begin
                // second half of the swap, and read of the next parent
                wr_en = 1'b1;
                wr_addr = idx_reg;
                wr_data = oth_ent_reg;
                idx_next = oth_reg;
                if (oth_reg == '0)
                begin
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    oth_next = up_parent;
                    rd_addr = up_parent;
                    state_next = S_INS_CMP;
                end
            end
            S_EXT_RD0:
            begin
                // root arrives; read the last entry, count already shrunk
                res_next = rd_data;
                rd_addr = count_reg[AW-1:0];
                state_next = S_EXT_RDL;
            end
            S_EXT_RDL:
            begin
                // last entry becomes the new root and sinks from there
                node_next = rd_data;
                idx_next = '0;
                if (count_reg == '0)
                begin
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (CW'(1) < count_reg)
                begin
                    rd_addr = AW'(1);
                    state_next = S_SK_RDL;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = '0;
                    wr_data = rd_data;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SK_RDL:
            begin
                // left child arrives; issue the right read
                lft_next = rd_data;
                rd_addr = rchild[AW-1:0];
                state_next = S_SK_RDR;
            end
            S_SK_RDR:
            begin
                if (worse(order_reg, node_reg, ch_ent))
                begin
                    // child moves up into the hole, node goes one level down
                    wr_en = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = ch_ent;
                    idx_next = ch_idx;
                    if (ch_lchild < IW'(count_reg))
                    begin
                        rd_addr = ch_lchild[AW-1:0];
                        state_next = S_SK_RDL;
                    end
                    else
                    begin
                        state_next = S_SK_FIN;
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SK_FIN:
            begin
                // node settles at a leaf
                wr_en = 1'b1;
                rsp_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            order_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            status_reg <= '0;
            res_reg <= '0;
            idx_reg <= '0;
            oth_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg <= status_next;
            res_reg <= res_next;
            idx_reg <= idx_next;
            oth_reg <= oth_next;
            if (cfg_we)
            begin
                order_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        oth_ent_reg <= oth_ent_next;
        lft_reg <= lft_next;
    end

    // count never exceeds the store depth
    `ASSERT_CLK(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH), "count above depth")
    // no new request while the sequencer is busy
    `ASSERT_CLK(a_no_accept_busy, clk, rst_n, !(req.ready && (state_reg != S_IDLE)), "ready while busy")
    // a waiting result beat stays until taken
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid_reg && !rsp.ready, rsp_valid_reg, "lost beat")
endmodule

// ===== bench/bhpq_chan_if.sv =====
`timescale 1ns / 100ps
// beat detection on the request and result handshakes
// no dependencies
module bhpq_chan_mon (
    input  logic req_valid,
    input  logic req_ready,
    input  logic rsp_valid,
    input  logic rsp_ready,
    output logic req_beat,
    output logic rsp_beat
);
    assign req_beat = req_valid && req_ready;
    assign rsp_beat = rsp_valid && rsp_ready;
endmodule

// ===== bench/bhpq_checker.sv =====
`timescale 1ns / 100ps
// heap predictor and result comparison for the priority queue bench
// depends on bhpq_pkg, bhpq_req_if, bhpq_rsp_if, bhpq_chan_mon
module bhpq_checker #(
    parameter int DEPTH = 256
) (
    input logic      clk,
    input logic      rst_n,
    input logic      order_mode,
    bhpq_req_if      req,
    bhpq_rsp_if      rsp,
    output int       fail_count,
    output int       pending
);
    typedef struct packed {
        logic [31:0] k;
        logic [31:0] p;
    } slot_t;

    typedef struct packed {
        bhpq_pkg::status_t status;
        logic [31:0] key;
        logic [31:0] payload;
        logic [8:0]  count;
    } result_t;

    slot_t   heap_q [DEPTH];
    int      heap_n;
    result_t result_q [$];
    logic    req_beat;
    logic    rsp_beat;

    bhpq_chan_mon i_mon (
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .req_beat  (req_beat),
        .rsp_beat  (rsp_beat)
    );

    function automatic bit below(int a, int b);
        if (order_mode)
            return heap_q[a].k < heap_q[b].k;
        return heap_q[a].k > heap_q[b].k;
    endfunction

    function automatic void swap_slots(int a, int b);
        slot_t t;
        t = heap_q[a];
        heap_q[a] = heap_q[b];
        heap_q[b] = t;
    endfunction

    function automatic result_t heap_apply(logic rt, logic [31:0] k, logic [31:0] p);
        result_t r;
        int i;
        int c;
        r = '0;
        if (rt == bhpq_pkg::REQ_INSERT)
        begin
            if (heap_n >= DEPTH)
            begin
                r.status = bhpq_pkg::ST_FULL;
            end
            else
            begin
                heap_q[heap_n] = '{k: k, p: p};
                i = heap_n;
                heap_n++;
                while (i > 0 && below((i - 1) / 2, i))
                begin
                    swap_slots((i - 1) / 2, i);
                    i = (i - 1) / 2;
                end
                r.status = bhpq_pkg::ST_INSERTED;
            end
        end
        else if (heap_n == 0)
        begin
            r.status = bhpq_pkg::ST_EMPTY;
        end
        else
        begin
            heap_n--;
            swap_slots(0, heap_n);
            r.key = heap_q[heap_n].k;
            r.payload = heap_q[heap_n].p;
            i = 0;
            while (2 * i + 1 < heap_n)
            begin
                c = 2 * i + 1;
                if (c + 1 < heap_n && below(c, c + 1))
                    c++;
                if (!below(i, c))
                    break;
                swap_slots(i, c);
                i = c;
            end
            r.status = bhpq_pkg::ST_EXTRACTED;
        end
        r.count = heap_n[8:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            heap_n = 0;
            fail_count = 0;
            result_q.delete();
        end
        else
        begin
            if (rsp_beat)
            begin
                got = '{status: bhpq_pkg::status_t'(rsp.status), key: rsp.out_key,
                        payload: rsp.out_payload, count: rsp.count};
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (req_beat)
                result_q.push_back(heap_apply(req.req_type, req.key, req.payload));
        end
        pending = result_q.size();
    end
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// top of the priority queue bench: clock, reset, stimulus and verdict
// depends on bhpq_pkg, the channel interfaces, bhpq_checker and the rtl top
module tb;
    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic order_mode = 1'b0;   // mirror of the register for the checker
    int   fail_count;
    int   pending;
    int   cycles = 0;

    bhpq_req_if req ();
    bhpq_rsp_if rsp ();

    always #6 clk = ~clk;

    binary_heap_priority_queue #(.DEPTH(DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    bhpq_checker #(.DEPTH(DEPTH)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .order_mode (order_mode),
        .req        (req),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall before each beat, with calm stretches
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    // one request beat, after a random gap if gaps is set; valid held until accepted
    task automatic send_beat(logic rt, logic [31:0] k, logic [31:0] p, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.req_type <= rt;
        req.key <= k;
        req.payload <= p;
        do @(posedge clk); while (!req.ready);
    endtask

    // wait for every result, then let the block settle (used before each register write)
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_order(logic mode);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        order_mode <= mode;
        @(posedge clk);
    endtask

    // random key, often from a narrow range so that ties are frequent
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int level;
        bit gaps;
        req.valid = 1'b0;
        req.req_type = bhpq_pkg::REQ_INSERT;
        req.key = '0;
        req.payload = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extract on empty, extremes of the fields, ties
        send_beat(bhpq_pkg::REQ_EXTRACT, '0, '0, 1'b0);
        send_beat(bhpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h0, 32'h0, 1'b0);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h5, 32'hA5A5_A5A5, 1'b1);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h5, 32'h5A5A_5A5A, 1'b1);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h5, 32'h1234_5678, 1'b1);
        repeat (6) send_beat(bhpq_pkg::REQ_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

        // max order, same shape
        set_order(1'b1);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h0, 32'h1, 1'b0);
        send_beat(bhpq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h2, 1'b0);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h8000_0000, 32'h3, 1'b0);
        send_beat(bhpq_pkg::REQ_INSERT, 32'h8000_0000, 32'h4, 1'b0);
        repeat (5) send_beat(bhpq_pkg::REQ_EXTRACT, '0, '0, 1'b0);

        // random phases: walk the fill level up and down, full heap in one of them
        for (int ph = 0; ph < 4; ph++)
        begin
            set_order(ph[0]);
            for (int n = 0; n < (ph == 2 ? 300 : 110); n++)
            begin
                gaps = ($urandom_range(0, 4) != 0);
                if (ph == 2)
                    level = (n < 265) ? 100 : 5;    // fill past the top then drain
                else
                    level = (n < 60) ? 70 : 30;
                send_beat(($urandom_range(0, 99) < level) ? bhpq_pkg::REQ_INSERT
                                                          : bhpq_pkg::REQ_EXTRACT,
                          pick_key(), $urandom, gaps);
                if (n == 50)
                    drain();   // sender holds off until the block is quiet
            end
        end

        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
